### hw/rtl/hrlc_pkg.sv
// ----------------------------------------------------------------------------
// HTTP request line checker package
// Shared types, phase and result codes, character constants and the small
// character-class tables used by the request line parser.
// ----------------------------------------------------------------------------
package hrlc_pkg;

    // Parser phases within one request line.
    localparam logic [2:0] PH_METHOD  = 3'd0;
    localparam logic [2:0] PH_PATH    = 3'd1;
    localparam logic [2:0] PH_QUERY   = 3'd2;
    localparam logic [2:0] PH_VERSION = 3'd3;
    localparam logic [2:0] PH_TAIL    = 3'd4;

    // Result kinds.
    localparam logic [1:0] KIND_PATH    = 2'd0;
    localparam logic [1:0] KIND_QUERY   = 2'd1;
    localparam logic [1:0] KIND_VERDICT = 2'd2;

    // Verdict and internal error codes share one encoding.
    localparam logic [1:0] VERDICT_OK          = 2'd0;
    localparam logic [1:0] VERDICT_BAD_REQUEST = 2'd1;
    localparam logic [1:0] VERDICT_NOT_ALLOWED = 2'd2;

    // Configuration register indexes.
    localparam logic CFG_MAX_PATH_LEN  = 1'b0;
    localparam logic CFG_MAX_QUERY_LEN = 1'b1;

    localparam logic [7:0] MAX_PATH_RESET  = 8'd96;
    localparam logic [7:0] MAX_QUERY_RESET = 8'd31;

    // Characters with a special meaning.
    localparam logic [7:0] CH_NUL     = 8'h00;
    localparam logic [7:0] CH_LF      = 8'h0a;
    localparam logic [7:0] CH_CR      = 8'h0d;
    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] CH_PERCENT = 8'h25;
    localparam logic [7:0] CH_AMP     = 8'h26;
    localparam logic [7:0] CH_PLUS    = 8'h2b;
    localparam logic [7:0] CH_MINUS   = 8'h2d;
    localparam logic [7:0] CH_DOT     = 8'h2e;
    localparam logic [7:0] CH_SLASH   = 8'h2f;
    localparam logic [7:0] CH_EQUAL   = 8'h3d;
    localparam logic [7:0] CH_QUEST   = 8'h3f;
    localparam logic [7:0] CH_BSLASH  = 8'h5c;
    localparam logic [7:0] CH_UNDER   = 8'h5f;
    localparam logic [7:0] CH_TILDE   = 8'h7e;
    localparam logic [7:0] CH_G       = 8'h47;
    localparam logic [7:0] CH_H       = 8'h48;

    localparam logic [2:0] GET_LEN  = 3'd4;
    localparam logic [2:0] HEAD_LEN = 3'd5;
    localparam logic [2:0] VER_LEN  = 3'd7;

    // Configuration registers.
    typedef struct packed {
        logic [7:0] max_path_len;
        logic [7:0] max_query_len;
    } cfg_t;

    // One result item.
    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] data_byte;
        logic [1:0] verdict;
        logic       method_head;
        logic [7:0] path_count;
        logic [7:0] query_count;
    } result_t;

    // Expected byte of "GET " at a position.
    function automatic logic [7:0] get_char(input logic [2:0] idx);
        logic [7:0] c;
        unique case (idx)
            3'd0:    c = 8'h47;
            3'd1:    c = 8'h45;
            3'd2:    c = 8'h54;
            3'd3:    c = 8'h20;
            default: c = 8'h00;
        endcase
        return c;
    endfunction

    // Expected byte of "HEAD " at a position.
    function automatic logic [7:0] head_char(input logic [2:0] idx);
        logic [7:0] c;
        unique case (idx)
            3'd0:    c = 8'h48;
            3'd1:    c = 8'h45;
            3'd2:    c = 8'h41;
            3'd3:    c = 8'h44;
            3'd4:    c = 8'h20;
            default: c = 8'h00;
        endcase
        return c;
    endfunction

    // Expected byte of "HTTP/1." at a position.
    function automatic logic [7:0] ver_char(input logic [2:0] idx);
        logic [7:0] c;
        unique case (idx)
            3'd0:    c = 8'h48;
            3'd1:    c = 8'h54;
            3'd2:    c = 8'h54;
            3'd3:    c = 8'h50;
            3'd4:    c = 8'h2f;
            3'd5:    c = 8'h31;
            3'd6:    c = 8'h2e;
            default: c = 8'h00;
        endcase
        return c;
    endfunction

    // Hex digit decode: bit 4 flags a valid digit, bits 3:0 hold its value.
    function automatic logic [4:0] hex_decode(input logic [7:0] c);
        logic [4:0] r;
        r = 5'd0;
        if (c >= 8'h30 && c <= 8'h39) begin
            r = {1'b1, 4'(c - 8'h30)};
        end else if (c >= 8'h61 && c <= 8'h66) begin
            r = {1'b1, 4'(c - 8'h57)};
        end else if (c >= 8'h41 && c <= 8'h46) begin
            r = {1'b1, 4'(c - 8'h37)};
        end
        return r;
    endfunction

    function automatic logic is_alnum(input logic [7:0] c);
        return (c >= 8'h61 && c <= 8'h7a) || (c >= 8'h41 && c <= 8'h5a) ||
               (c >= 8'h30 && c <= 8'h39);
    endfunction

    function automatic logic path_allowed(input logic [7:0] c);
        return is_alnum(c) || c == CH_DOT || c == CH_UNDER || c == CH_MINUS ||
               c == CH_TILDE;
    endfunction

    function automatic logic query_allowed(input logic [7:0] c);
        return path_allowed(c) || c == CH_EQUAL || c == CH_AMP || c == CH_PERCENT ||
               c == CH_PLUS;
    endfunction

endpackage

### hw/rtl/hrlc_in_stage.sv
// ----------------------------------------------------------------------------
// Input register
// Holds one accepted line byte until the parser consumes it; a new transfer
// is taken in the same cycle the held byte leaves.
// ----------------------------------------------------------------------------
module hrlc_in_stage (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_byte,
    input  logic       consume,
    output logic       in_valid,
    output logic [7:0] in_byte
);

    logic       valid_reg;
    logic       valid_next;
    logic [7:0] byte_reg;

    assign s_tready = !valid_reg || consume;
    assign in_valid = valid_reg;
    assign in_byte  = byte_reg;

    // Valid flag: set on a transfer, cleared when the byte is consumed.
    always_comb begin
        valid_next = valid_reg;
        if (s_tvalid && s_tready) begin
            valid_next = 1'b1;
        end else if (consume) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    // Payload register.
    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            byte_reg <= s_byte;
        end
    end

endmodule

### hw/rtl/hrlc_parser.sv
// ----------------------------------------------------------------------------
// Request line parser
// Line state and the per-byte update: method match, path decode and check,
// query check, version prefix and the verdict at CR LF.
// ----------------------------------------------------------------------------
module hrlc_parser (
    input  logic              aclk,
    input  logic              aresetn,
    input  hrlc_pkg::cfg_t    cfg,
    input  logic              in_valid,
    input  logic [7:0]        in_byte,
    output logic              consume,
    input  logic              out_ready,
    output logic              res_valid,
    output hrlc_pkg::result_t res
);
    import hrlc_pkg::*;

    // Line state.
    logic [2:0] phase_reg,     phase_next;
    logic [2:0] idx_reg,       idx_next;
    logic       method_reg,    method_next;
    logic [1:0] pct_reg,       pct_next;
    logic [3:0] hi_reg,        hi_next;
    logic [1:0] seg_len_reg,   seg_len_next;
    logic       seg_dots_reg,  seg_dots_next;
    logic       seen_reg,      seen_next;
    logic [7:0] plen_reg,      plen_next;
    logic [7:0] qlen_reg,      qlen_next;
    logic [1:0] err_reg,       err_next;
    logic       pend_reg,      pend_next;

    // Working values of the byte update.
    logic       emit;
    logic       bad;
    logic       dec_go;
    logic       dec_raw;
    logic [7:0] dec_c;
    logic [4:0] hex;
    logic [7:0] b;

    assign b       = in_byte;
    assign hex     = hex_decode(in_byte);
    assign consume = in_valid && (!emit || out_ready);
    assign res_valid = in_valid && emit;

    // Next line state and result for the byte at the input register.
    always_comb begin
        phase_next    = phase_reg;
        idx_next      = idx_reg;
        method_next   = method_reg;
        pct_next      = pct_reg;
        hi_next       = hi_reg;
        seg_len_next  = seg_len_reg;
        seg_dots_next = seg_dots_reg;
        seen_next     = seen_reg;
        plen_next     = plen_reg;
        qlen_next     = qlen_reg;
        err_next      = err_reg;
        pend_next     = pend_reg;
        emit          = 1'b0;
        bad           = 1'b0;
        dec_go        = 1'b0;
        dec_raw       = 1'b0;
        dec_c         = b;
        res           = '0;

        if (pend_reg && b == CH_LF) begin
            // Line end: give the verdict, then start a fresh line.
            emit            = 1'b1;
            res.kind        = KIND_VERDICT;
            res.path_count  = plen_reg;
            res.query_count = qlen_reg;
            res.verdict     = err_reg;
            if (err_reg == VERDICT_OK) begin
                if (phase_reg == PH_TAIL) begin
                    res.method_head = method_reg;
                end else if (phase_reg == PH_METHOD) begin
                    res.verdict = VERDICT_NOT_ALLOWED;
                end else begin
                    res.verdict = VERDICT_BAD_REQUEST;
                end
            end
            phase_next    = PH_METHOD;
            idx_next      = '0;
            method_next   = 1'b0;
            pct_next      = '0;
            hi_next       = '0;
            seg_len_next  = '0;
            seg_dots_next = 1'b1;
            seen_next     = 1'b0;
            plen_next     = '0;
            qlen_next     = '0;
            err_next      = VERDICT_OK;
            pend_next     = 1'b0;
        end else begin
            // A held CR not followed by LF is an ordinary byte; it is refused
            // everywhere except in the version tail.
            if (pend_reg) begin
                pend_next = 1'b0;
                if (err_reg == VERDICT_OK && phase_reg != PH_TAIL) begin
                    err_next = (phase_reg == PH_METHOD) ? VERDICT_NOT_ALLOWED
                                                        : VERDICT_BAD_REQUEST;
                end
            end

            if (b == CH_CR) begin
                pend_next = 1'b1;
            end else if (err_next == VERDICT_OK) begin
                unique case (phase_reg)
                    PH_METHOD: begin
                        if (idx_reg == 3'd0) begin
                            if (b == CH_G) begin
                                method_next = 1'b0;
                                idx_next    = 3'd1;
                            end else if (b == CH_H) begin
                                method_next = 1'b1;
                                idx_next    = 3'd1;
                            end else begin
                                err_next = VERDICT_NOT_ALLOWED;
                            end
                        end else if (!method_reg) begin
                            if (idx_reg >= GET_LEN || b != get_char(idx_reg)) begin
                                err_next = VERDICT_NOT_ALLOWED;
                            end else if (idx_reg + 3'd1 == GET_LEN) begin
                                phase_next = PH_PATH;
                                idx_next   = '0;
                            end else begin
                                idx_next = idx_reg + 3'd1;
                            end
                        end else begin
                            if (idx_reg >= HEAD_LEN || b != head_char(idx_reg)) begin
                                err_next = VERDICT_NOT_ALLOWED;
                            end else if (idx_reg + 3'd1 == HEAD_LEN) begin
                                phase_next = PH_PATH;
                                idx_next   = '0;
                            end else begin
                                idx_next = idx_reg + 3'd1;
                            end
                        end
                    end
                    PH_PATH: begin
                        if (pct_reg == 2'd1) begin
                            // High digit of an escape.
                            if (!hex[4]) begin
                                bad = 1'b1;
                            end else begin
                                hi_next  = hex[3:0];
                                pct_next = 2'd2;
                            end
                        end else if (pct_reg == 2'd2) begin
                            // Low digit of an escape; slash, backslash and zero
                            // may not be escaped.
                            if (!hex[4]) begin
                                bad = 1'b1;
                            end else begin
                                pct_next = 2'd0;
                                hi_next  = '0;
                                dec_c    = {hi_reg, hex[3:0]};
                                if (dec_c == CH_NUL || dec_c == CH_SLASH ||
                                    dec_c == CH_BSLASH) begin
                                    bad = 1'b1;
                                end else begin
                                    dec_go = 1'b1;
                                end
                            end
                        end else if (!seen_reg && b != CH_SLASH) begin
                            bad = 1'b1;
                        end else if (b == CH_SLASH) begin
                            dec_go  = 1'b1;
                            dec_raw = 1'b1;
                        end else if (b == CH_QUEST || b == CH_SPACE) begin
                            // Path end: the last segment may be empty, not a
                            // dot segment.
                            if (!seen_reg || (seg_dots_reg &&
                                (seg_len_reg == 2'd1 || seg_len_reg == 2'd2))) begin
                                bad = 1'b1;
                            end
                            if (b == CH_QUEST) begin
                                phase_next = PH_QUERY;
                            end else begin
                                phase_next = PH_VERSION;
                                idx_next   = '0;
                            end
                        end else if (b == CH_PERCENT) begin
                            pct_next = 2'd1;
                        end else if (b == CH_BSLASH || b == CH_NUL) begin
                            bad = 1'b1;
                        end else begin
                            dec_go = 1'b1;
                        end
                    end
                    PH_QUERY: begin
                        if (b == CH_SPACE) begin
                            phase_next = PH_VERSION;
                            idx_next   = '0;
                        end else if (!query_allowed(b)) begin
                            bad = 1'b1;
                        end else begin
                            if (qlen_reg != 8'hff) begin
                                qlen_next = qlen_reg + 8'd1;
                            end
                            if (qlen_next > cfg.max_query_len) begin
                                bad = 1'b1;
                            end else begin
                                emit            = 1'b1;
                                res.kind        = KIND_QUERY;
                                res.data_byte   = b;
                                res.path_count  = plen_reg;
                                res.query_count = qlen_next;
                            end
                        end
                    end
                    PH_VERSION: begin
                        if (idx_reg >= VER_LEN || b != ver_char(idx_reg)) begin
                            bad = 1'b1;
                        end else begin
                            idx_next = idx_reg + 3'd1;
                            if (idx_reg + 3'd1 == VER_LEN) begin
                                phase_next = PH_TAIL;
                            end
                        end
                    end
                    PH_TAIL: begin
                        if (b == CH_SPACE || b == CH_NUL) begin
                            bad = 1'b1;
                        end
                    end
                    default: begin
                        bad = 1'b1;
                    end
                endcase

                // One decoded path byte: segment checks, length and output.
                if (dec_go) begin
                    if (dec_raw) begin
                        if (seen_reg && (seg_len_reg == 2'd0 ||
                            (seg_dots_reg && seg_len_reg <= 2'd2))) begin
                            bad = 1'b1;
                        end
                        seen_next     = 1'b1;
                        seg_len_next  = '0;
                        seg_dots_next = 1'b1;
                    end else if (!path_allowed(dec_c)) begin
                        bad = 1'b1;
                    end else begin
                        if (seg_len_reg != 2'd3) begin
                            seg_len_next = seg_len_reg + 2'd1;
                        end
                        if (dec_c != CH_DOT) begin
                            seg_dots_next = 1'b0;
                        end
                    end
                    if (dec_raw || path_allowed(dec_c)) begin
                        if (plen_reg != 8'hff) begin
                            plen_next = plen_reg + 8'd1;
                        end
                        if (plen_next > cfg.max_path_len) begin
                            bad = 1'b1;
                        end
                        if (!bad) begin
                            emit            = 1'b1;
                            res.kind        = KIND_PATH;
                            res.data_byte   = dec_c;
                            res.path_count  = plen_next;
                            res.query_count = qlen_reg;
                        end
                    end
                end

                if (bad) begin
                    err_next = VERDICT_BAD_REQUEST;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg    <= PH_METHOD;
            idx_reg      <= '0;
            method_reg   <= 1'b0;
            pct_reg      <= '0;
            hi_reg       <= '0;
            seg_len_reg  <= '0;
            seg_dots_reg <= 1'b1;
            seen_reg     <= 1'b0;
            plen_reg     <= '0;
            qlen_reg     <= '0;
            err_reg      <= VERDICT_OK;
            pend_reg     <= 1'b0;
        end else if (consume) begin
            phase_reg    <= phase_next;
            idx_reg      <= idx_next;
            method_reg   <= method_next;
            pct_reg      <= pct_next;
            hi_reg       <= hi_next;
            seg_len_reg  <= seg_len_next;
            seg_dots_reg <= seg_dots_next;
            seen_reg     <= seen_next;
            plen_reg     <= plen_next;
            qlen_reg     <= qlen_next;
            err_reg      <= err_next;
            pend_reg     <= pend_next;
        end
    end

    // Path and query bytes only leave while the line is still clean.
    a_data_only_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        (consume && res_valid && res.kind != KIND_VERDICT) |-> err_reg == VERDICT_OK)
        else $error("data byte emitted after an error");

    // An ok verdict is only given once the version prefix is complete.
    a_ok_needs_tail: assert property (@(posedge aclk) disable iff (!aresetn)
        (consume && res_valid && res.kind == KIND_VERDICT && res.verdict == VERDICT_OK)
        |-> phase_reg == PH_TAIL)
        else $error("ok verdict before version prefix");

    // A verdict restarts the line.
    a_verdict_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        (consume && res_valid && res.kind == KIND_VERDICT)
        |=> (phase_reg == PH_METHOD && plen_reg == 8'd0 && err_reg == VERDICT_OK))
        else $error("line state not cleared after verdict");

endmodule

### hw/rtl/hrlc_out_stage.sv
// ----------------------------------------------------------------------------
// Output register
// Holds one result item until the downstream side takes the transfer.
// ----------------------------------------------------------------------------
module hrlc_out_stage (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              load,
    input  hrlc_pkg::result_t res,
    output logic              ready,
    output logic              m_tvalid,
    input  logic              m_tready,
    output hrlc_pkg::result_t m_res
);
    import hrlc_pkg::*;

    logic    valid_reg;
    logic    valid_next;
    result_t res_reg;

    assign ready    = !valid_reg || m_tready;
    assign m_tvalid = valid_reg;
    assign m_res    = res_reg;

    // Full while a result waits; a load may replace a result leaving now.
    always_comb begin
        valid_next = valid_reg;
        if (load) begin
            valid_next = 1'b1;
        end else if (m_tready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            res_reg <= res;
        end
    end

endmodule

### hw/rtl/http_request_line_checker_top.sv
// ----------------------------------------------------------------------------
// HTTP request line checker, top level
// Checks request lines byte by byte and streams decoded path bytes, query
// bytes and one verdict per line.
// ----------------------------------------------------------------------------
// The block takes one line byte per cycle and sustains that rate without
// gaps while the result stream accepts results: a byte is parsed once it
// sits in the input register, and any result it causes is registered in the
// output register before it appears on the master side. The rate is set by
// the per-byte update of the line state. One input register and one
// output register separate the two sides, so one more byte is taken while a
// result waits. Configuration writes take effect at once and are meant for
// times when no line is in flight.
module http_request_line_checker_top (
    input  logic        aclk,
    input  logic        aresetn,
    // Configuration write port: index 0 max_path_len, index 1 max_query_len.
    input  logic        cfg_we,
    input  logic        cfg_addr,
    input  logic [7:0]  cfg_wdata,
    // Input stream.
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,    // [7:0] line_byte
    // Result stream.
    output logic        m_tvalid,
    input  logic        m_tready,
    // [7:0] data_byte, [9:8] verdict, [10] method_head, [18:11] path_count,
    // [26:19] query_count, [31:27] zero
    output logic [31:0] m_tdata,
    output logic [1:0]  m_tuser     // [1:0] kind
);
    import hrlc_pkg::*;

    cfg_t       cfg_reg;
    logic       in_valid;
    logic [7:0] in_byte;
    logic       consume;
    logic       out_ready;
    logic       res_valid;
    result_t    res;
    result_t    m_res;

    // Configuration registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.max_path_len  <= MAX_PATH_RESET;
            cfg_reg.max_query_len <= MAX_QUERY_RESET;
        end else if (cfg_we) begin
            unique case (cfg_addr)
                CFG_MAX_PATH_LEN:  cfg_reg.max_path_len  <= cfg_wdata;
                CFG_MAX_QUERY_LEN: cfg_reg.max_query_len <= cfg_wdata;
                default: ;
            endcase
        end
    end

    hrlc_in_stage u_in_stage (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_byte   (s_tdata),
        .consume  (consume),
        .in_valid (in_valid),
        .in_byte  (in_byte)
    );

    hrlc_parser u_parser (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg_reg),
        .in_valid  (in_valid),
        .in_byte   (in_byte),
        .consume   (consume),
        .out_ready (out_ready),
        .res_valid (res_valid),
        .res       (res)
    );

    hrlc_out_stage u_out_stage (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .load     (res_valid && out_ready),
        .res      (res),
        .ready    (out_ready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_res    (m_res)
    );

    // Pack the result fields onto the stream.
    assign m_tdata = {5'd0, m_res.query_count, m_res.path_count, m_res.method_head,
                      m_res.verdict, m_res.data_byte};
    assign m_tuser = m_res.kind;

endmodule
